// ----- rtl/lsu_pkg.sv -----
package lsu_pkg;

  // Configuration register indexes.
  localparam logic [1:0] REG_TIME_STEP      = 2'd0;
  localparam logic [1:0] REG_INV_DX_SQUARED = 2'd1;
  localparam logic [1:0] REG_INV_DY_SQUARED = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [31:0] TIME_STEP_RESET = 32'd6554;
  localparam logic [31:0] INV_DX_RESET    = 32'd65536;
  localparam logic [31:0] INV_DY_RESET    = 32'd65536;

  // Pipeline depth figures.
  localparam int AXIS_STAGES = 6;
  localparam int SQRT_CELLS  = 32;
  localparam int BACK_STAGES = 4;
  localparam int PIPE_STAGES = AXIS_STAGES + 1 + SQRT_CELLS + BACK_STAGES;

  // Width of the partial remainder inside the square root chain.
  localparam int REM_W = 34;

  // Per-cell data that rides along the whole pipeline.
  typedef struct packed {
    logic signed [31:0] center;
    logic               pos;
    logic [31:0]        speed_mag;
  } side_t;

endpackage

// ----- rtl/lsu_axis.sv -----
module lsu_axis #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic [lsu_pkg::AXIS_STAGES-1:0]     en,
  input  logic signed [31:0]                  m2,
  input  logic signed [31:0]                  m1,
  input  logic signed [31:0]                  c,
  input  logic signed [31:0]                  p1,
  input  logic signed [31:0]                  p2,
  input  logic                                pos,
  input  logic [31:0]                         inv,
  output logic [63:0]                         term
);

  function automatic logic [34:0] abs35(input logic signed [34:0] v);
    abs35 = v[34] ? 35'(-v) : 35'(v);
  endfunction

  // Stage A: second differences and raw first differences.
  logic signed [34:0] am, bc, ap, dmr, dpr;
  logic               pos_a;
  always_ff @(posedge clk) begin
    if (en[0]) begin
      am    <= 35'(c) - (35'(m1) <<< 1) + 35'(m2);
      bc    <= 35'(p1) - (35'(c) <<< 1) + 35'(m1);
      ap    <= 35'(p2) - (35'(p1) <<< 1) + 35'(c);
      dmr   <= (35'(c) - 35'(m1)) <<< 1;
      dpr   <= (35'(p1) - 35'(c)) <<< 1;
      pos_a <= pos;
    end
  end

  // Stage B: ENO2 correction of smaller magnitude, upwind clamp, saturation.
  logic signed [34:0] cm, cp;
  logic signed [35:0] dm, dp, dm_keep, dp_keep;
  logic [35:0]        dm_abs, dp_abs;
  logic [31:0]        dm_mag, dp_mag;
  always_comb begin
    cm = (abs35(am) > abs35(bc)) ? bc : am;
    cp = (abs35(bc) > abs35(ap)) ? ap : bc;
    dm = 36'(dmr) + 36'(cm);
    dp = 36'(dpr) - 36'(cp);
    if (pos_a) begin
      dm_keep = (dm > 0) ? dm : '0;
      dp_keep = (dp < 0) ? -dp : '0;
    end else begin
      dm_keep = (dm < 0) ? -dm : '0;
      dp_keep = (dp > 0) ? dp : '0;
    end
    dm_abs = 36'(dm_keep);
    dp_abs = 36'(dp_keep);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      dm_mag <= (|dm_abs[35:32]) ? '1 : dm_abs[31:0];
      dp_mag <= (|dp_abs[35:32]) ? '1 : dp_abs[31:0];
    end
  end

  // Stage C: squares of the slope magnitudes.
  logic [63:0] sqm, sqp;
  always_ff @(posedge clk) begin
    if (en[2]) begin
      sqm <= 64'(dm_mag) * 64'(dm_mag);
      sqp <= 64'(dp_mag) * 64'(dp_mag);
    end
  end

  // Stage D: saturating sum of squares.
  logic [64:0] sq_sum;
  logic [63:0] sq;
  assign sq_sum = 65'(sqm) + 65'(sqp);
  always_ff @(posedge clk) begin
    if (en[3]) begin
      sq <= sq_sum[64] ? '1 : sq_sum[63:0];
    end
  end

  // Stage E: two partial products against the grid weight.
  logic [63:0] pp_lo, pp_hi;
  always_ff @(posedge clk) begin
    if (en[4]) begin
      pp_lo <= 64'(sq[31:0]) * 64'(inv);
      pp_hi <= 64'(sq[63:32]) * 64'(inv);
    end
  end

  // Stage F: combine, scale down and saturate to 64 bits.
  logic [95:0] full, scaled;
  assign full   = {pp_hi, 32'd0} + 96'(pp_lo);
  assign scaled = full >> (FRAC_BITS + 2);
  always_ff @(posedge clk) begin
    if (en[5]) begin
      term <= (|scaled[95:64]) ? '1 : scaled[63:0];
    end
  end

endmodule

// ----- rtl/lsu_sqrt_cell.sv -----
module lsu_sqrt_cell (
  input  logic                        clk,
  input  logic                        en,
  input  logic [63:0]                 rad_in,
  input  logic [lsu_pkg::REM_W-1:0]   rem_in,
  input  logic [31:0]                 root_in,
  input  lsu_pkg::side_t              side_in,
  output logic [63:0]                 rad_out,
  output logic [lsu_pkg::REM_W-1:0]   rem_out,
  output logic [31:0]                 root_out,
  output lsu_pkg::side_t              side_out
);

  // One result bit per cell: bring down two radicand bits and try a subtract.
  logic [lsu_pkg::REM_W+1:0] work, trial, diff;
  logic                      take;
  assign work  = {rem_in, rad_in[63:62]};
  assign trial = {2'b00, root_in, 2'b01};
  assign diff  = work - trial;
  assign take  = (work >= trial);

  always_ff @(posedge clk) begin
    if (en) begin
      rad_out  <= {rad_in[61:0], 2'b00};
      rem_out  <= take ? diff[lsu_pkg::REM_W-1:0] : work[lsu_pkg::REM_W-1:0];
      root_out <= {root_in[30:0], take};
      side_out <= side_in;
    end
  end

endmodule

// ----- rtl/level_set_eno2_upwind_update_unit.sv -----
// Level-set ENO2 upwind update, one grid cell per transaction.
// Input channel (in_valid/in_ready): speed, the center value and its four
// neighbors along x and y, all signed fixed point with FRAC_BITS fraction.
// Output channel (out_valid/out_ready): new_value and the saturated flag,
// exactly one result per input, in input order.
// Configuration: write_enable, write_index and write_data set time_step,
// inv_dx_squared and inv_dy_squared; write only while no cell is in flight.
// Throughput is one cell per cycle while out_ready holds. The stages from
// acceptance to out_valid: six per axis front end, one for the axis sum,
// 32 square root cells (one result bit each) and four back-end stages.
// Each stage advances when it is empty or its successor advances, so the
// pipeline keeps taking cells while a result waits, until it fills up.
// When the receiver stalls the results back up stage by stage and in_ready
// falls only once the stage at the input holds data that cannot move.
// Reset clears all valid flags and restores the register reset values.
module level_set_eno2_upwind_update_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               write_enable,
  input  logic [1:0]         write_index,
  input  logic [31:0]        write_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] speed,
  input  logic signed [31:0] center_value,
  input  logic signed [31:0] x_minus_two,
  input  logic signed [31:0] x_minus_one,
  input  logic signed [31:0] x_plus_one,
  input  logic signed [31:0] x_plus_two,
  input  logic signed [31:0] y_minus_two,
  input  logic signed [31:0] y_minus_one,
  input  logic signed [31:0] y_plus_one,
  input  logic signed [31:0] y_plus_two,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] new_value,
  output logic               saturated
);

  localparam int NS   = lsu_pkg::PIPE_STAGES;
  localparam int AS   = lsu_pkg::AXIS_STAGES;
  localparam int SQ0  = AS + 1;
  localparam int BK0  = SQ0 + lsu_pkg::SQRT_CELLS;

  // Configuration registers.
  logic [31:0] time_step, inv_dx_squared, inv_dy_squared;
  always_ff @(posedge clk) begin
    if (rst) begin
      time_step      <= lsu_pkg::TIME_STEP_RESET;
      inv_dx_squared <= lsu_pkg::INV_DX_RESET;
      inv_dy_squared <= lsu_pkg::INV_DY_RESET;
    end else if (write_enable) begin
      unique case (write_index)
        lsu_pkg::REG_TIME_STEP:      time_step      <= write_data;
        lsu_pkg::REG_INV_DX_SQUARED: inv_dx_squared <= write_data;
        lsu_pkg::REG_INV_DY_SQUARED: inv_dy_squared <= write_data;
        default: ;
      endcase
    end
  end

  // Stage valid flags and the advance chain running back from the output.
  logic [NS-1:0] vld;
  logic [NS:0]   adv;
  assign adv[NS] = out_ready;
  genvar gi;
  generate
    for (gi = 0; gi < NS; gi++) begin : g_adv
      assign adv[gi] = !vld[gi] || adv[gi+1];
    end
  endgenerate
  assign in_ready  = adv[0];
  assign out_valid = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int i = 0; i < NS; i++) begin
        if (adv[i]) begin
          vld[i] <= (i == 0) ? in_valid : vld[(i == 0) ? 0 : i-1];
        end
      end
    end
  end

  // Side data for the front stages.
  lsu_pkg::side_t side_in;
  lsu_pkg::side_t side_f [AS+1];
  assign side_in.center    = center_value;
  assign side_in.pos       = (speed > 0);
  assign side_in.speed_mag = speed[31] ? 32'(-speed) : 32'(speed);

  always_ff @(posedge clk) begin
    for (int i = 0; i <= AS; i++) begin
      if (adv[i]) begin
        side_f[i] <= (i == 0) ? side_in : side_f[(i == 0) ? 0 : i-1];
      end
    end
  end

  // Axis front ends.
  logic [63:0] term_x, term_y;
  lsu_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_x (
    .clk  (clk),
    .en   (adv[AS-1:0]),
    .m2   (x_minus_two),
    .m1   (x_minus_one),
    .c    (center_value),
    .p1   (x_plus_one),
    .p2   (x_plus_two),
    .pos  (side_in.pos),
    .inv  (inv_dx_squared),
    .term (term_x)
  );
  lsu_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_y (
    .clk  (clk),
    .en   (adv[AS-1:0]),
    .m2   (y_minus_two),
    .m1   (y_minus_one),
    .c    (center_value),
    .p1   (y_plus_one),
    .p2   (y_plus_two),
    .pos  (side_in.pos),
    .inv  (inv_dy_squared),
    .term (term_y)
  );

  // Saturating sum of the two axis terms.
  logic [64:0] sum_xy;
  logic [63:0] radicand;
  assign sum_xy = 65'(term_x) + 65'(term_y);
  always_ff @(posedge clk) begin
    if (adv[AS]) begin
      radicand <= sum_xy[64] ? '1 : sum_xy[63:0];
    end
  end

  // Square root chain.
  logic [63:0]               rad  [lsu_pkg::SQRT_CELLS+1];
  logic [lsu_pkg::REM_W-1:0] rem  [lsu_pkg::SQRT_CELLS+1];
  logic [31:0]               root [lsu_pkg::SQRT_CELLS+1];
  lsu_pkg::side_t            side_s [lsu_pkg::SQRT_CELLS+1];
  assign rad[0]    = radicand;
  assign rem[0]    = '0;
  assign root[0]   = '0;
  assign side_s[0] = side_f[AS];

  generate
    for (gi = 0; gi < lsu_pkg::SQRT_CELLS; gi++) begin : g_sqrt
      lsu_sqrt_cell u_cell (
        .clk      (clk),
        .en       (adv[SQ0+gi]),
        .rad_in   (rad[gi]),
        .rem_in   (rem[gi]),
        .root_in  (root[gi]),
        .side_in  (side_s[gi]),
        .rad_out  (rad[gi+1]),
        .rem_out  (rem[gi+1]),
        .root_out (root[gi+1]),
        .side_out (side_s[gi+1])
      );
    end
  endgenerate

  // Back end stage 1: time step times gradient norm.
  logic [63:0]    dtg;
  lsu_pkg::side_t side_b1;
  always_ff @(posedge clk) begin
    if (adv[BK0]) begin
      dtg     <= 64'(time_step) * 64'(root[lsu_pkg::SQRT_CELLS]);
      side_b1 <= side_s[lsu_pkg::SQRT_CELLS];
    end
  end

  // Back end stage 2: partial products against the speed magnitude.
  logic [63:0]    qq_lo, qq_hi;
  lsu_pkg::side_t side_b2;
  always_ff @(posedge clk) begin
    if (adv[BK0+1]) begin
      qq_lo   <= 64'(dtg[31:0]) * 64'(side_b1.speed_mag);
      qq_hi   <= 64'(dtg[63:32]) * 64'(side_b1.speed_mag);
      side_b2 <= side_b1;
    end
  end

  // Back end stage 3: scale down and clamp the update magnitude.
  logic [95:0]    qfull, qscaled;
  logic [33:0]    mag;
  lsu_pkg::side_t side_b3;
  assign qfull   = {qq_hi, 32'd0} + 96'(qq_lo);
  assign qscaled = qfull >> (2 * FRAC_BITS);
  always_ff @(posedge clk) begin
    if (adv[BK0+2]) begin
      mag     <= (qscaled > 96'h2_0000_0000) ? 34'h2_0000_0000 : qscaled[33:0];
      side_b3 <= side_b2;
    end
  end

  // Output stage: apply the update against the speed sign and saturate.
  logic signed [35:0] upd;
  assign upd = side_b3.pos ? (36'(side_b3.center) - 36'(mag))
                           : (36'(side_b3.center) + 36'(mag));
  always_ff @(posedge clk) begin
    if (adv[BK0+3]) begin
      if (upd > 36'sd2147483647) begin
        new_value <= 32'sh7fffffff;
        saturated <= 1'b1;
      end else if (upd < -36'sd2147483648) begin
        new_value <= 32'sh80000000;
        saturated <= 1'b1;
      end else begin
        new_value <= upd[31:0];
        saturated <= 1'b0;
      end
    end
  end

endmodule
